@@ rtl/trs_pkg.sv @@
// shared types and constants for the transform compose pipeline
// no dependencies; used by trs_scale_round and trs_transform_compose_top
package trs_pkg;

   // quaternion component, signed Q2.14
   typedef logic signed [15:0] quat_type;
   // uniform scale, signed Q8.16
   typedef logic signed [23:0] scale_type;
   // position and matrix outputs, signed Q16.16
   typedef logic signed [31:0] word_type;
   // pairwise quaternion product, exact in Q4.28
   typedef logic signed [31:0] prod_type;
   // rotation element before scaling, exact in Q.28 with headroom for 1 - 2(a+b)
   typedef logic signed [33:0] elem_type;
   // element times scale, exact in Q.44
   typedef logic signed [57:0] wide_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } pos_type;

   localparam int ElemCount = 9;
   localparam int FracShift = 28;

   localparam elem_type OneQ28  = elem_type'(1) <<< FracShift;
   localparam wide_type HalfQ28 = wide_type'(1) <<< (FracShift - 1);

   // sign-extend a quaternion product into element width
   function automatic elem_type ext_prod(input prod_type p);
      return elem_type'(p);
   endfunction

endpackage

@@ rtl/trs_scale_round.sv @@
// one rotation element times the uniform scale, rounded to Q16.16 and saturated
// two register stages: product, then round and clamp; uses trs_pkg
module trs_scale_round (
   input  logic               clock,
   input  trs_pkg::elem_type  elem,
   input  trs_pkg::scale_type scale_val,
   output trs_pkg::word_type  mat_out
);
   import trs_pkg::*;

   wide_type mult_in;
   wide_type mult_ff;
   wide_type rnd_sum;
   logic signed [57-FracShift:0] rnd_q;
   word_type res_in;
   word_type res_ff;

   // exact product, one 34x24 multiplier
   assign mult_in = wide_type'(elem) * wide_type'(scale_val);

   always_ff @(posedge clock) begin
      mult_ff <= mult_in;
   end

   // add half an lsb and floor: nearest, ties toward plus infinity
   assign rnd_sum = mult_ff + HalfQ28;
   assign rnd_q   = rnd_sum[57:FracShift];

   // clamp to the signed 32-bit range
   always_comb begin
      priority if (wide_type'(rnd_q) > wide_type'(32'sh7fff_ffff)) begin
         res_in = 32'sh7fff_ffff;
      end else if (wide_type'(rnd_q) < wide_type'(32'sh8000_0000)) begin
         res_in = 32'sh8000_0000;
      end else begin
         res_in = word_type'(rnd_q);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign mat_out = res_ff;

endmodule

@@ rtl/trs_transform_compose_top.sv @@
// Transform composer: position, quaternion and uniform scale in, 4x3 affine matrix out.
// Five-stage pipeline, one item per clock; uses trs_pkg and trs_scale_round.
//
// An item is taken at every clock edge with start high; busy is always low, since the
// pipeline never stalls. Each item's result appears on the rsp_ ports for exactly one
// cycle with rsp_strobe high, in the order the items came in. The stages
// are: input register, nine 16x16 quaternion products, the nine Q.28 rotation elements,
// nine 34x24 scale products, then rounding to nearest (ties up) with saturation. The
// quaternion is used as given, with no normalization; the position is passed through
// unchanged. Each result passes through the five register stages of the multiply-add
// path; throughput is one item per clock.
module trs_transform_compose_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  trs_pkg::word_type  req_pos_x,
   input  trs_pkg::word_type  req_pos_y,
   input  trs_pkg::word_type  req_pos_z,
   input  trs_pkg::quat_type  req_quat_x,
   input  trs_pkg::quat_type  req_quat_y,
   input  trs_pkg::quat_type  req_quat_z,
   input  trs_pkg::quat_type  req_quat_w,
   input  trs_pkg::scale_type req_scale_factor,
   output logic               rsp_strobe,
   output trs_pkg::word_type  rsp_m00,
   output trs_pkg::word_type  rsp_m01,
   output trs_pkg::word_type  rsp_m02,
   output trs_pkg::word_type  rsp_m10,
   output trs_pkg::word_type  rsp_m11,
   output trs_pkg::word_type  rsp_m12,
   output trs_pkg::word_type  rsp_m20,
   output trs_pkg::word_type  rsp_m21,
   output trs_pkg::word_type  rsp_m22,
   output trs_pkg::word_type  rsp_tr_x,
   output trs_pkg::word_type  rsp_tr_y,
   output trs_pkg::word_type  rsp_tr_z
);
   import trs_pkg::*;

   localparam int Depth = 5;

   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;
   pos_type          pos_ff [Depth];

   quat_type  qx_ff, qy_ff, qz_ff, qw_ff;
   scale_type s1_ff, s2_ff, s3_ff;

   prod_type  xx_ff, xy_ff, xz_ff, xw_ff, yy_ff, yz_ff, yw_ff, zz_ff, zw_ff;
   elem_type  elem_in [ElemCount];
   elem_type  elem_ff [ElemCount];
   word_type  mat     [ElemCount];

   // pipeline never holds off an item
   assign busy = 1'b0;

   // valid bits travel alongside the data
   assign valid_in = {valid_ff[Depth-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // position delay line, matched to the element path
   always_ff @(posedge clock) begin
      pos_ff[0] <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
      for (int i = 1; i < Depth; i++) begin
         pos_ff[i] <= pos_ff[i-1];
      end
   end

   // stage 1: input register
   always_ff @(posedge clock) begin
      qx_ff <= req_quat_x;
      qy_ff <= req_quat_y;
      qz_ff <= req_quat_z;
      qw_ff <= req_quat_w;
      s1_ff <= req_scale_factor;
   end

   // stage 2: pairwise quaternion products, exact in Q4.28
   always_ff @(posedge clock) begin
      xx_ff <= prod_type'(qx_ff) * prod_type'(qx_ff);
      xy_ff <= prod_type'(qx_ff) * prod_type'(qy_ff);
      xz_ff <= prod_type'(qx_ff) * prod_type'(qz_ff);
      xw_ff <= prod_type'(qx_ff) * prod_type'(qw_ff);
      yy_ff <= prod_type'(qy_ff) * prod_type'(qy_ff);
      yz_ff <= prod_type'(qy_ff) * prod_type'(qz_ff);
      yw_ff <= prod_type'(qy_ff) * prod_type'(qw_ff);
      zz_ff <= prod_type'(qz_ff) * prod_type'(qz_ff);
      zw_ff <= prod_type'(qz_ff) * prod_type'(qw_ff);
      s2_ff <= s1_ff;
   end

   // stage 3: rotation elements in Q.28, doubling as a shift
   always_comb begin
      elem_in[0] = OneQ28 - ((ext_prod(yy_ff) + ext_prod(zz_ff)) <<< 1);
      elem_in[1] = (ext_prod(xy_ff) + ext_prod(zw_ff)) <<< 1;
      elem_in[2] = (ext_prod(xz_ff) - ext_prod(yw_ff)) <<< 1;
      elem_in[3] = (ext_prod(xy_ff) - ext_prod(zw_ff)) <<< 1;
      elem_in[4] = OneQ28 - ((ext_prod(xx_ff) + ext_prod(zz_ff)) <<< 1);
      elem_in[5] = (ext_prod(yz_ff) + ext_prod(xw_ff)) <<< 1;
      elem_in[6] = (ext_prod(xz_ff) + ext_prod(yw_ff)) <<< 1;
      elem_in[7] = (ext_prod(yz_ff) - ext_prod(xw_ff)) <<< 1;
      elem_in[8] = OneQ28 - ((ext_prod(xx_ff) + ext_prod(yy_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ElemCount; i++) begin
         elem_ff[i] <= elem_in[i];
      end
      s3_ff <= s2_ff;
   end

   // stages 4 and 5: scale, round and saturate each element
   for (genvar g = 0; g < ElemCount; g++) begin : g_elem
      trs_scale_round u_scale (
         .clock     (clock),
         .elem      (elem_ff[g]),
         .scale_val (s3_ff),
         .mat_out   (mat[g])
      );
   end

   // result ports
   assign rsp_strobe = valid_ff[Depth-1];
   assign rsp_m00    = mat[0];
   assign rsp_m01    = mat[1];
   assign rsp_m02    = mat[2];
   assign rsp_m10    = mat[3];
   assign rsp_m11    = mat[4];
   assign rsp_m12    = mat[5];
   assign rsp_m20    = mat[6];
   assign rsp_m21    = mat[7];
   assign rsp_m22    = mat[8];
   assign rsp_tr_x   = pos_ff[Depth-1].x;
   assign rsp_tr_y   = pos_ff[Depth-1].y;
   assign rsp_tr_z   = pos_ff[Depth-1].z;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for trs_transform_compose_top: directed and random items,
// predicted results compared field by field in arrival order. Depends on rtl/trs_pkg.sv
// and the RTL of trs_transform_compose_top.
module tb;
   import trs_pkg::*;

   localparam int CycleLimit = 100000;
   localparam int TailCycles = 12;

   // one input item as driven on the req_ ports
   typedef struct packed {
      word_type  pos_x;
      word_type  pos_y;
      word_type  pos_z;
      quat_type  quat_x;
      quat_type  quat_y;
      quat_type  quat_z;
      quat_type  quat_w;
      scale_type scale;
   } trs_item_type;

   // one composed transform: rot[0] is m00, rot[8] is m22
   typedef struct packed {
      word_type [8:0] rot;
      pos_type        tr;
   } xform_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   word_type  req_pos_x;
   word_type  req_pos_y;
   word_type  req_pos_z;
   quat_type  req_quat_x;
   quat_type  req_quat_y;
   quat_type  req_quat_z;
   quat_type  req_quat_w;
   scale_type req_scale_factor;
   logic      rsp_strobe;
   word_type  rsp_m00, rsp_m01, rsp_m02;
   word_type  rsp_m10, rsp_m11, rsp_m12;
   word_type  rsp_m20, rsp_m21, rsp_m22;
   word_type  rsp_tr_x, rsp_tr_y, rsp_tr_z;

   xform_type pending_xforms[$];
   int        mismatch_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;

   trs_transform_compose_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_quat_x       (req_quat_x),
      .req_quat_y       (req_quat_y),
      .req_quat_z       (req_quat_z),
      .req_quat_w       (req_quat_w),
      .req_scale_factor (req_scale_factor),
      .rsp_strobe       (rsp_strobe),
      .rsp_m00          (rsp_m00),
      .rsp_m01          (rsp_m01),
      .rsp_m02          (rsp_m02),
      .rsp_m10          (rsp_m10),
      .rsp_m11          (rsp_m11),
      .rsp_m12          (rsp_m12),
      .rsp_m20          (rsp_m20),
      .rsp_m21          (rsp_m21),
      .rsp_m22          (rsp_m22),
      .rsp_tr_x         (rsp_tr_x),
      .rsp_tr_y         (rsp_tr_y),
      .rsp_tr_z         (rsp_tr_z)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL trs_transform_compose_top");
         $finish;
      end
   end

   // scaled rotation element: round to nearest with ties up, then saturate
   function automatic word_type scale_elem(input longint elem, input longint s);
      longint rounded;
      rounded = (elem * s + (longint'(1) <<< 27)) >>> 28;
      if (rounded > longint'(32'sh7fffffff))
         rounded = longint'(32'sh7fffffff);
      if (rounded < -longint'(64'sh80000000))
         rounded = -longint'(64'sh80000000);
      return word_type'(rounded);
   endfunction

   // expected transform for one item
   function automatic xform_type compose_xform(input trs_item_type it);
      xform_type res;
      longint    qx, qy, qz, qw, s;
      longint    xx, xy, xz, xw, yy, yz, yw, zz, zw;
      longint    one;
      longint    elem [9];
      qx  = longint'(it.quat_x);
      qy  = longint'(it.quat_y);
      qz  = longint'(it.quat_z);
      qw  = longint'(it.quat_w);
      s   = longint'(it.scale);
      one = longint'(1) <<< 28;
      xx = qx * qx; xy = qx * qy; xz = qx * qz; xw = qx * qw;
      yy = qy * qy; yz = qy * qz; yw = qy * qw;
      zz = qz * qz; zw = qz * qw;
      elem[0] = one - 2 * (yy + zz);
      elem[1] = 2 * (xy + zw);
      elem[2] = 2 * (xz - yw);
      elem[3] = 2 * (xy - zw);
      elem[4] = one - 2 * (xx + zz);
      elem[5] = 2 * (yz + xw);
      elem[6] = 2 * (xz + yw);
      elem[7] = 2 * (yz - xw);
      elem[8] = one - 2 * (xx + yy);
      for (int i = 0; i < 9; i++)
         res.rot[i] = scale_elem(elem[i], s);
      res.tr.x = it.pos_x;
      res.tr.y = it.pos_y;
      res.tr.z = it.pos_z;
      return res;
   endfunction

   function automatic trs_item_type make_item(input word_type px, input word_type py,
                                              input word_type pz, input quat_type qx,
                                              input quat_type qy, input quat_type qz,
                                              input quat_type qw, input scale_type s);
      trs_item_type it;
      it = '{pos_x: px, pos_y: py, pos_z: pz, quat_x: qx, quat_y: qy, quat_z: qz,
             quat_w: qw, scale: s};
      return it;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // send one item, idling each cycle with the set chance, and record its expected transform
   task automatic send_item(input trs_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_pos_x        <= it.pos_x;
      req_pos_y        <= it.pos_y;
      req_pos_z        <= it.pos_z;
      req_quat_x       <= it.quat_x;
      req_quat_y       <= it.quat_y;
      req_quat_z       <= it.quat_z;
      req_quat_w       <= it.quat_w;
      req_scale_factor <= it.scale;
      forever begin
         @(posedge clock);
         if (busy === 1'b0) break;
      end
      pending_xforms.push_back(compose_xform(it));
   endtask

   // lower start and hold off until every expected transform has come back
   task automatic wait_all_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_xforms.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      xform_type want;
      xform_type got;
      if (!reset && rsp_strobe !== 1'b0) begin
         got.rot = {rsp_m22, rsp_m21, rsp_m20, rsp_m12, rsp_m11, rsp_m10,
                    rsp_m02, rsp_m01, rsp_m00};
         got.tr  = {rsp_tr_x, rsp_tr_y, rsp_tr_z};
         if (rsp_strobe !== 1'b1) begin
            report_mismatch("rsp_strobe unknown");
         end else if (pending_xforms.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_xforms.pop_front();
            for (int i = 0; i < 9; i++)
               if (got.rot[i] !== want.rot[i])
                  report_mismatch($sformatf("m%0d%0d got %h want %h", i / 3, i % 3,
                                            got.rot[i], want.rot[i]));
            if (got.tr.x !== want.tr.x)
               report_mismatch($sformatf("tr_x got %h want %h", got.tr.x, want.tr.x));
            if (got.tr.y !== want.tr.y)
               report_mismatch($sformatf("tr_y got %h want %h", got.tr.y, want.tr.y));
            if (got.tr.z !== want.tr.z)
               report_mismatch($sformatf("tr_z got %h want %h", got.tr.z, want.tr.z));
         end
      end
   end

   // field extremes, identity, zero and negative scale, rounding ties, unnormalized input
   task automatic test_directed();
      send_idle_pct = 0;
      send_item(make_item(32'sh7fffffff, 32'sh80000000, 32'sh00010000,
                          16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000, 24'sh010000));
      send_item(make_item(32'sh80000000, 32'sh7fffffff, 32'shffffffff,
                          16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000, 24'sh010000));
      send_item(make_item(32'sh00000000, 32'sh00000000, 32'sh00000000,
                          16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 24'sh000000));
      send_item(make_item(32'sh12345678, 32'shedcba987, 32'sh00000001,
                          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 24'sh800000));
      send_item(make_item(32'shffffffff, 32'sh00000000, 32'sh7fffffff,
                          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 24'sh7fffff));
      send_item(make_item(32'sh00000000, 32'shffffffff, 32'sh80000000,
                          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 24'shff0000));
      send_item(make_item(32'sh00010000, 32'sh00020000, 32'sh00030000,
                          16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 24'sh7fffff));
      // quarter turn about z
      send_item(make_item(32'sh00050000, 32'shfffb0000, 32'sh00000000,
                          16'sh0000, 16'sh0000, 16'sh2d41, 16'sh2d41, 24'sh010000));
      // ties round toward plus infinity
      send_item(make_item(32'sh00000000, 32'sh00000000, 32'sh00000000,
                          16'sh2000, 16'sh0001, 16'sh0000, 16'sh0000, 24'sh002000));
      send_item(make_item(32'sh00000000, 32'sh00000000, 32'sh00000000,
                          16'sh2000, 16'sh0001, 16'sh0000, 16'sh0000, 24'shffe000));
      // zero scale with a unit quaternion
      send_item(make_item(32'sh00001111, 32'sh00002222, 32'sh00003333,
                          16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000, 24'sh000000));
      // negative scale, unnormalized quaternion
      send_item(make_item(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
                          16'sh5a5a, 16'sha5a5, 16'sh1234, 16'shc000, 24'sh800001));
      send_item(make_item(32'sh00000000, 32'sh00000000, 32'sh00000000,
                          16'sh0001, 16'shffff, 16'sh0001, 16'shffff, 24'sh000001));
      send_item(make_item(32'sh00000000, 32'sh00000000, 32'sh00000000,
                          16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000, 24'shffffff));
   endtask

   // random component of at most unit magnitude, or anywhere in range
   function automatic quat_type rand_component(input bit near_unit);
      int mag;
      if (!near_unit) return quat_type'($urandom);
      mag = $urandom_range(0, 16384);
      return quat_type'($urandom_range(0, 1) ? -mag : mag);
   endfunction

   function automatic scale_type rand_scale();
      case ($urandom_range(0, 3))
         0:       return scale_type'(24'sh010000);
         1:       return scale_type'($urandom_range(0, 262144)) - scale_type'(131072);
         default: return scale_type'($urandom);
      endcase
   endfunction

   task automatic test_random(input int idle_pct, input int count);
      bit near_unit;
      send_idle_pct = idle_pct;
      repeat (count) begin
         near_unit = ($urandom_range(0, 99) < 40);
         send_item(make_item(word_type'($urandom), word_type'($urandom),
                             word_type'($urandom), rand_component(near_unit),
                             rand_component(near_unit), rand_component(near_unit),
                             rand_component(near_unit), rand_scale()));
      end
   endtask

   // back-to-back burst, then a pause until the pipeline is empty
   task automatic test_burst_and_drain();
      send_idle_pct = 0;
      repeat (20)
         send_item(make_item(word_type'($urandom), word_type'($urandom),
                             word_type'($urandom), quat_type'($urandom),
                             quat_type'($urandom), quat_type'($urandom),
                             quat_type'($urandom), scale_type'($urandom)));
      wait_all_results();
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_pos_z        = '0;
      req_quat_x       = '0;
      req_quat_y       = '0;
      req_quat_z       = '0;
      req_quat_w       = '0;
      req_scale_factor = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(28, 170);
      test_burst_and_drain();
      test_random(47, 170);
      test_random(0, 170);

      wait_all_results();
      repeat (TailCycles) @(posedge clock);
      if (pending_xforms.size() != 0)
         report_mismatch($sformatf("%0d results never came", pending_xforms.size()));
      if (mismatch_count == 0) begin
         $display("PASS trs_transform_compose_top");
      end else begin
         $display("FAIL trs_transform_compose_top");
      end
      $finish;
   end

endmodule

@@ trs_transform_compose_top.f @@
rtl/trs_pkg.sv
rtl/trs_scale_round.sv
rtl/trs_transform_compose_top.sv
tb/tb.sv
